FILE: hw/rtl/sit_pkg.sv
// shared constant for the segment intersection test
`default_nettype none

package sit_pkg;

    // default coordinate width, two's complement
    localparam int COORD_BITS_DEFAULT = 24;

endpackage

`default_nettype wire

FILE: hw/rtl/segment_intersection_test.sv
// Segment intersection test: takes segments AB and CD, tells whether they meet.
// Input channel (in_valid/in_ready) carries one beat per segment pair: points
// A (first_start), B (first_end), C (second_start) and D (second_end), each
// coordinate COORD_BITS wide, two's complement.
// Output channel (out_valid/out_ready) carries one beat per input beat: hit.
// count_touch is written through cfg_we/cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce; 1 counts touching contact as a hit, 0 asks for a proper crossing.
// Four register stages: coordinate differences and box bounds, the eight
// orientation products with the box overlap compares, the determinant
// subtracts, and the final decision in the output register.
// One pair enters per cycle unless the receiver stalls the output;
// the product stage runs eight multipliers in parallel.
// Reset clears all stage valid bits and count_touch; no pair is held over.
// When the receiver holds out_ready low, stages fill up behind the output
// register and in_ready falls once all four are full; nothing is lost or repeated.
`default_nettype none

module segment_intersection_test #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] first_start_x,
    input  wire logic signed [COORD_BITS-1:0] first_start_y,
    input  wire logic signed [COORD_BITS-1:0] first_end_x,
    input  wire logic signed [COORD_BITS-1:0] first_end_y,
    input  wire logic signed [COORD_BITS-1:0] second_start_x,
    input  wire logic signed [COORD_BITS-1:0] second_start_y,
    input  wire logic signed [COORD_BITS-1:0] second_end_x,
    input  wire logic signed [COORD_BITS-1:0] second_end_y,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              hit
);

    import sit_pkg::*;

    localparam int DW = COORD_BITS + 1;  // difference width
    localparam int PW = 2 * DW;          // product width
    localparam int SW = PW + 1;          // determinant width

    // configuration register
    logic count_touch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_touch_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            count_touch_reg <= cfg_wdata;
        end
    end

    // stage advance chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: differences and box bounds
    logic signed [DW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    assign ax = DW'(first_start_x);
    assign ay = DW'(first_start_y);
    assign bx = DW'(first_end_x);
    assign by = DW'(first_end_y);
    assign cx = DW'(second_start_x);
    assign cy = DW'(second_start_y);
    assign dx = DW'(second_end_x);
    assign dy = DW'(second_end_y);

    logic signed [DW-1:0] bax_reg, bay_reg, cax_reg, cay_reg, dax_reg, day_reg;
    logic signed [DW-1:0] dcx_reg, dcy_reg, acx_reg, acy_reg, bcx_reg, bcy_reg;
    logic signed [COORD_BITS-1:0] abx_lo_reg, abx_hi_reg, aby_lo_reg, aby_hi_reg;
    logic signed [COORD_BITS-1:0] cdx_lo_reg, cdx_hi_reg, cdy_lo_reg, cdy_hi_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            bax_reg <= bx - ax;
            bay_reg <= by - ay;
            cax_reg <= cx - ax;
            cay_reg <= cy - ay;
            dax_reg <= dx - ax;
            day_reg <= dy - ay;
            dcx_reg <= dx - cx;
            dcy_reg <= dy - cy;
            acx_reg <= ax - cx;
            acy_reg <= ay - cy;
            bcx_reg <= bx - cx;
            bcy_reg <= by - cy;
            abx_lo_reg <= (first_start_x > first_end_x) ? first_end_x : first_start_x;
            abx_hi_reg <= (first_start_x > first_end_x) ? first_start_x : first_end_x;
            aby_lo_reg <= (first_start_y > first_end_y) ? first_end_y : first_start_y;
            aby_hi_reg <= (first_start_y > first_end_y) ? first_start_y : first_end_y;
            cdx_lo_reg <= (second_start_x > second_end_x) ? second_end_x : second_start_x;
            cdx_hi_reg <= (second_start_x > second_end_x) ? second_start_x : second_end_x;
            cdy_lo_reg <= (second_start_y > second_end_y) ? second_end_y : second_start_y;
            cdy_hi_reg <= (second_start_y > second_end_y) ? second_start_y : second_end_y;
        end
    end

    // stage 2: orientation products and box overlap
    logic signed [PW-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg;
    logic signed [PW-1:0] p3a_reg, p3b_reg, p4a_reg, p4b_reg;
    logic                 touch_ov_reg, strict_ov_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            p1a_reg <= bax_reg * cay_reg;
            p1b_reg <= bay_reg * cax_reg;
            p2a_reg <= bax_reg * day_reg;
            p2b_reg <= bay_reg * dax_reg;
            p3a_reg <= dcx_reg * acy_reg;
            p3b_reg <= dcy_reg * acx_reg;
            p4a_reg <= dcx_reg * bcy_reg;
            p4b_reg <= dcy_reg * bcx_reg;
            touch_ov_reg <= (abx_hi_reg >= cdx_lo_reg) && (cdx_hi_reg >= abx_lo_reg)
                         && (aby_hi_reg >= cdy_lo_reg) && (cdy_hi_reg >= aby_lo_reg);
            strict_ov_reg <= (abx_hi_reg > cdx_lo_reg) && (cdx_hi_reg > abx_lo_reg)
                          && (aby_hi_reg > cdy_lo_reg) && (cdy_hi_reg > aby_lo_reg);
        end
    end

    // stage 3: determinant signs
    logic signed [SW-1:0] det1, det2, det3, det4;
    logic [3:0]           zero_reg, neg_reg;
    logic                 touch_ov3_reg, strict_ov3_reg;

    assign det1 = SW'(p1a_reg) - SW'(p1b_reg);
    assign det2 = SW'(p2a_reg) - SW'(p2b_reg);
    assign det3 = SW'(p3a_reg) - SW'(p3b_reg);
    assign det4 = SW'(p4a_reg) - SW'(p4b_reg);

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            zero_reg <= {det4 == '0, det3 == '0, det2 == '0, det1 == '0};
            neg_reg  <= {det4[SW-1], det3[SW-1], det2[SW-1], det1[SW-1]};
            touch_ov3_reg  <= touch_ov_reg;
            strict_ov3_reg <= strict_ov_reg;
        end
    end

    // stage 4: decision into the output register
    logic collinear;
    logic touch_ab, touch_cd, cross_ab, cross_cd;
    logic hit_next, hit_reg;

    assign collinear = &zero_reg;
    assign touch_ab  = zero_reg[0] || zero_reg[1] || (neg_reg[0] ^ neg_reg[1]);
    assign touch_cd  = zero_reg[2] || zero_reg[3] || (neg_reg[2] ^ neg_reg[3]);
    assign cross_ab  = !zero_reg[0] && !zero_reg[1] && (neg_reg[0] ^ neg_reg[1]);
    assign cross_cd  = !zero_reg[2] && !zero_reg[3] && (neg_reg[2] ^ neg_reg[3]);

    always_comb
    begin
        priority if (collinear)
        begin
            hit_next = count_touch_reg ? touch_ov3_reg : strict_ov3_reg;
        end
        else if (count_touch_reg)
        begin
            hit_next = touch_ab && touch_cd;
        end
        else
        begin
            hit_next = cross_ab && cross_cd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = v4_reg;
    assign hit       = hit_reg;

endmodule

`default_nettype wire

FILE: tb/tb_segment_intersection_test.sv
// testbench for segment_intersection_test: queued driver, checking monitor, exact predictor
`default_nettype none

module tb_segment_intersection_test;

    localparam int CW = sit_pkg::COORD_BITS_DEFAULT;
    localparam longint CMIN = -(longint'(1) << (CW - 1));
    localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES = 3;

    typedef struct {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    typedef struct {
        seg_pair_t pair;
        logic      hit;
    } hit_expect_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    seg_pair_t cur_pair = '{default: '0};

    seg_pair_t   pair_queue[$];
    hit_expect_t expected_hits[$];
    logic touch_mode = 1'b0;
    logic tx_hold = 1'b0;
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   tx_gap = 0;
    int   tx_burst = 0;
    int   rx_stall = 0;
    int   rx_burst = 0;
    int   fault_count = 0;
    int   idle_cycles = 0;

    segment_intersection_test #(
        .COORD_BITS(CW)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_start_x (cur_pair.ax),
        .first_start_y (cur_pair.ay),
        .first_end_x   (cur_pair.bx),
        .first_end_y   (cur_pair.by),
        .second_start_x(cur_pair.cx),
        .second_start_y(cur_pair.cy),
        .second_end_x  (cur_pair.dx),
        .second_end_y  (cur_pair.dy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit           (hit)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sign of the cross product (b - a) x (p - a)
    function automatic int orient_sign(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
        longint det;
        det = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
        return (det > 0) ? 1 : ((det < 0) ? -1 : 0);
    endfunction

    // exact intersection decision for one segment pair
    function automatic logic segments_meet(seg_pair_t p, logic touch);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint abx0, abx1, aby0, aby1, cdx0, cdx1, cdy0, cdy1;
        int s1, s2, s3, s4;
        logic meet;
        ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
        cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
        s1 = orient_sign(ax, ay, bx, by, cx, cy);
        s2 = orient_sign(ax, ay, bx, by, dx, dy);
        s3 = orient_sign(cx, cy, dx, dy, ax, ay);
        s4 = orient_sign(cx, cy, dx, dy, bx, by);
        if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0)
        begin
            // collinear: bounding box overlap on both axes
            abx0 = (ax < bx) ? ax : bx;
            abx1 = (ax < bx) ? bx : ax;
            aby0 = (ay < by) ? ay : by;
            aby1 = (ay < by) ? by : ay;
            cdx0 = (cx < dx) ? cx : dx;
            cdx1 = (cx < dx) ? dx : cx;
            cdy0 = (cy < dy) ? cy : dy;
            cdy1 = (cy < dy) ? dy : cy;
            if (touch)
                meet = !(abx1 < cdx0 || cdx1 < abx0 || aby1 < cdy0 || cdy1 < aby0);
            else
                meet = abx1 > cdx0 && cdx1 > abx0 && aby1 > cdy0 && cdy1 > aby0;
        end
        else if (touch)
            meet = (s1 * s2 <= 0) && (s3 * s4 <= 0);
        else
            meet = (s1 * s2 < 0) && (s3 * s4 < 0);
        return meet;
    endfunction

    function automatic longint rand_between(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic longint extreme_coord();
        case ($urandom_range(0, 5))
            0: return CMIN;
            1: return CMAX;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return rand_between(CMIN, CMAX);
        endcase
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic push_pair(longint ax, longint ay, longint bx, longint by,
                             longint cx, longint cy, longint dx, longint dy);
        seg_pair_t p;
        p.ax = ax[CW-1:0]; p.ay = ay[CW-1:0];
        p.bx = bx[CW-1:0]; p.by = by[CW-1:0];
        p.cx = cx[CW-1:0]; p.cy = cy[CW-1:0];
        p.dx = dx[CW-1:0]; p.dy = dy[CW-1:0];
        pair_queue.insert(pair_queue.size(), p);
    endtask

    // hand-picked geometry: crossings, touches, collinear and degenerate cases
    task automatic push_directed_pairs();
        push_pair(-100, -100, 100, 100, -100, 100, 100, -100);   // proper crossing
        push_pair(0, 0, 100, 0, 50, 0, 50, 50);                  // endpoint on interior
        push_pair(0, 0, 10, 10, 10, 10, 20, 0);                  // shared endpoint
        push_pair(0, 0, 10, 0, 20, 5, 30, -5);                   // apart, not parallel
        push_pair(0, 0, 10, 10, 0, 1, 10, 11);                   // parallel, offset
        push_pair(0, 0, 10, 10, 5, 5, 15, 15);                   // collinear overlap
        push_pair(0, 0, 10, 10, 10, 10, 20, 20);                 // collinear end to end
        push_pair(0, 0, 10, 10, 11, 11, 20, 20);                 // collinear apart
        push_pair(0, 0, 10, 0, 5, 0, 15, 0);                     // collinear horizontal
        push_pair(0, -7, 0, 7, 0, 3, 0, 9);                      // collinear vertical
        push_pair(5, 5, 5, 5, 0, 0, 10, 10);                     // point on segment
        push_pair(3, 4, 3, 4, 3, 4, 3, 4);                       // two equal points
        push_pair(0, 0, 0, 0, 0, 0, 0, 0);                       // all zero
        push_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        push_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX);
        push_pair(CMIN, CMIN + 1, CMAX, CMAX, 0, 0, CMAX, CMIN);
        push_pair(CMAX, CMIN, CMAX, CMAX, CMIN, 0, CMAX, 0);
    endtask

    // one random pair from a mix of geometric shapes
    task automatic push_random_pair();
        longint px[4], py[4];
        longint ox, oy, sx, sy;
        longint m, j;
        int kind;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            for (int i = 0; i < 4; i++)
            begin
                px[i] = $urandom();
                py[i] = $urandom();
            end
        end
        else if (kind < 48)
        begin
            // tiny grid, many touches and degenerate pairs
            for (int i = 0; i < 4; i++)
            begin
                px[i] = rand_between(-6, 6);
                py[i] = rand_between(-6, 6);
            end
        end
        else if (kind < 64)
        begin
            // four points on one line
            ox = rand_between(-4000000, 4000000);
            oy = rand_between(-4000000, 4000000);
            sx = rand_between(-1000, 1000);
            sy = rand_between(-1000, 1000);
            r = $urandom_range(0, 9);
            if (r < 2)
                sy = 0;
            else if (r < 4)
                sx = 0;
            for (int i = 0; i < 4; i++)
            begin
                m = rand_between(-40, 40);
                px[i] = ox + m * sx;
                py[i] = oy + m * sy;
            end
        end
        else if (kind < 80)
        begin
            // C lies on AB, D nearby
            px[0] = rand_between(-1000000, 1000000);
            py[0] = rand_between(-1000000, 1000000);
            sx = rand_between(-500, 500);
            sy = rand_between(-500, 500);
            m = rand_between(1, 40);
            j = rand_between(0, m);
            px[1] = px[0] + m * sx;
            py[1] = py[0] + m * sy;
            px[2] = px[0] + j * sx;
            py[2] = py[0] + j * sy;
            px[3] = px[2] + rand_between(-2000, 2000);
            py[3] = py[2] + rand_between(-2000, 2000);
            if ($urandom_range(0, 1))
            begin
                ox = px[0]; px[0] = px[1]; px[1] = ox;
                oy = py[0]; py[0] = py[1]; py[1] = oy;
            end
        end
        else if (kind < 90)
        begin
            for (int i = 0; i < 4; i++)
            begin
                px[i] = rand_between(-1000, 1000);
                py[i] = rand_between(-1000, 1000);
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                px[i] = extreme_coord();
                py[i] = extreme_coord();
            end
        end
        if ($urandom_range(0, 1))
            push_pair(px[2], py[2], px[3], py[3], px[0], py[0], px[1], py[1]);
        else
            push_pair(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
    endtask

    // wait until no beat is pending and every expected hit has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (in_valid || expected_hits.size() != 0 ||
               (!tx_hold && pair_queue.size() != 0));
    endtask

    task automatic set_touch_mode(logic mode);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        touch_mode = mode;
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (in_valid)
            begin
                if (tx_burst > 0)
                begin
                    tx_burst--;
                    tx_gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 24) == 0)
                        tx_burst = $urandom_range(20, 60);
                    tx_gap = pick_gap();
                end
            end
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (!tx_hold && pair_queue.size() != 0)
            begin
                cur_pair <= pair_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin
        if (out_taken)
        begin
            if (rx_burst > 0)
            begin
                rx_burst--;
                rx_stall = 0;
            end
            else
            begin
                if ($urandom_range(0, 24) == 0)
                    rx_burst = $urandom_range(20, 60);
                rx_stall = pick_gap();
            end
        end
        if (rx_stall > 0)
        begin
            rx_stall--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // monitor: check result beats, predict accepted pairs, watchdog
    always @(posedge clk)
    begin
        hit_expect_t exp_hit;
        in_taken <= in_valid && in_ready;
        out_taken <= out_valid && out_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected result beat: hit=%b", hit);
                    fault_count++;
                end
                else
                begin
                    exp_hit = expected_hits.pop_front();
                    if (hit !== exp_hit.hit)
                    begin
                        if (fault_count < 10)
                        begin
                            $write("hit mismatch: expected %b got %b ",
                                   exp_hit.hit, hit);
                            $display("A(%0d,%0d) B(%0d,%0d) C(%0d,%0d) D(%0d,%0d)",
                                     exp_hit.pair.ax, exp_hit.pair.ay,
                                     exp_hit.pair.bx, exp_hit.pair.by,
                                     exp_hit.pair.cx, exp_hit.pair.cy,
                                     exp_hit.pair.dx, exp_hit.pair.dy);
                        end
                        fault_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                exp_hit.pair = cur_pair;
                exp_hit.hit = segments_meet(cur_pair, touch_mode);
                expected_hits.insert(expected_hits.size(), exp_hit);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial
    begin
        int count;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed pairs in strict and touch mode
        set_touch_mode(1'b0);
        push_directed_pairs();
        wait_drained();
        set_touch_mode(1'b1);
        push_directed_pairs();
        wait_drained();

        // random phases, each with a mid-stream pause until all results return
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_touch_mode(phase != 1);
            count = (phase == RANDOM_PHASES - 1) ? 100 : 150;
            @(posedge clk);
            for (int i = 0; i < count; i++)
                push_random_pair();
            while (pair_queue.size() >= count / 2)
                @(posedge clk);
            tx_hold = 1'b1;
            wait_drained();
            tx_hold = 1'b0;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fault_count == 0 && expected_hits.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
